// ----- rtl/core/rau_pkg.sv -----
// Package for the rational arithmetic unit: widths, operation and status codes,
// state types, the interface structs of the reduce unit and the product schedule.
// Depends on nothing; used by rau_gcd_div and rational_arithmetic_unit.
`default_nettype none

package rau_pkg;

  // Fixed width of every fraction field on the ports.
  localparam int unsigned DW        = 32;
  // Exact intermediate width: a sum of two full products needs one bit more.
  localparam int unsigned ACC_W     = 2 * DW + 1;
  // Bit counter width for one pass of the restoring divider.
  localparam int unsigned CNT_W     = $clog2(DW);
  // Default wrap width of the results.
  localparam int unsigned RAU_WIDTH = 32;

  // Operation codes carried by each input word.
  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_NEG  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_ADDI = 3'd4,
    FN_RED  = 3'd5
  } rau_func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ZERO_DEN = 2'd1,
    STAT_OVERFLOW = 2'd2
  } rau_status_t;

  // Multiplier operand sources.
  typedef enum logic [1:0] {
    OPD_NA = 2'd0,
    OPD_DA = 2'd1,
    OPD_NB = 2'd2,
    OPD_DB = 2'd3
  } rau_opd_t;

  // One product step: two operands and the accumulator that takes the product.
  typedef struct packed {
    rau_opd_t x;
    rau_opd_t y;
    logic     to_den;
  } rau_uop_t;

  // Top level sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_RED,
    ST_DONE
  } rau_state_t;

  // Reduce unit sequencer states.
  typedef enum logic [2:0] {
    U_IDLE,
    U_GCD,
    U_SCALE,
    U_DIVN,
    U_DIVD,
    U_DONE
  } rau_ustate_t;

  // Request into the reduce unit: magnitudes of numerator and denominator.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] ma;
    logic [DW-1:0] md;
  } rau_red_req_t;

  // Response of the reduce unit: both magnitudes divided by their GCD.
  typedef struct packed {
    logic          done;
    logic [DW-1:0] qn;
    logic [DW-1:0] qd;
  } rau_red_rsp_t;

  // Product schedule of each cross-multiplying operation.
  function automatic rau_uop_t uop_of(logic [2:0] func, logic [1:0] step);
    rau_uop_t u;
    u = '{x: OPD_NA, y: OPD_NB, to_den: 1'b0};
    case (func)
      FN_ADD: begin
        case (step)
          2'd0:    u = '{x: OPD_NA, y: OPD_DB, to_den: 1'b0};
          2'd1:    u = '{x: OPD_DA, y: OPD_NB, to_den: 1'b0};
          default: u = '{x: OPD_DA, y: OPD_DB, to_den: 1'b1};
        endcase
      end
      FN_MUL: begin
        case (step)
          2'd0:    u = '{x: OPD_NA, y: OPD_NB, to_den: 1'b0};
          default: u = '{x: OPD_DA, y: OPD_DB, to_den: 1'b1};
        endcase
      end
      FN_DIV: begin
        case (step)
          2'd0:    u = '{x: OPD_NA, y: OPD_DB, to_den: 1'b0};
          default: u = '{x: OPD_DA, y: OPD_NB, to_den: 1'b1};
        endcase
      end
      FN_ADDI: u = '{x: OPD_NB, y: OPD_DA, to_den: 1'b0};
      default: u = '{x: OPD_NA, y: OPD_NB, to_den: 1'b0};
    endcase
    return u;
  endfunction

  // Index of the final product step of an operation.
  function automatic logic [1:0] last_step(logic [2:0] func);
    logic [1:0] s;
    case (func)
      FN_ADD:  s = 2'd2;
      FN_MUL:  s = 2'd1;
      FN_DIV:  s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rau_gcd_div.sv -----
// Reduce unit: binary GCD of two magnitudes, then two restoring divisions by it.
// One shared subtractor serves the GCD subtractions and both divisions. Depends on rau_pkg.
`default_nettype none

module rau_gcd_div
  import rau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rau_red_req_t req,
  output rau_red_rsp_t      rsp
);

  rau_ustate_t      state_r, state_nxt;
  logic [DW-1:0]    a_r, a_nxt;
  logic [DW-1:0]    b_r, b_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [DW-1:0]    ma_r, ma_nxt;
  logic [DW-1:0]    md_r, md_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    qn_r, qn_nxt;
  logic [DW-1:0]    qd_r, qd_nxt;

  logic [DW:0]      sub_x, sub_y;
  logic [DW+1:0]    diff;
  logic             borrow;
  logic [DW-1:0]    quo_step;
  logic [DW-1:0]    rem_step;
  logic             div_phase;

  assign div_phase = (state_r == U_DIVN) || (state_r == U_DIVD);

  // Shared subtractor: a - b while searching the GCD, remainder - divisor while dividing.
  always_comb begin
    if (div_phase) begin
      sub_x = {rem_r, quo_r[DW-1]};
      sub_y = {1'b0, a_r};
    end else begin
      sub_x = {1'b0, a_r};
      sub_y = {1'b0, b_r};
    end
    diff   = {1'b0, sub_x} - {1'b0, sub_y};
    borrow = diff[DW+1];
  end

  // One restoring division bit.
  always_comb begin
    quo_step = {quo_r[DW-2:0], ~borrow};
    if (borrow) begin
      rem_step = sub_x[DW-1:0];
    end else begin
      rem_step = diff[DW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          state_nxt = U_GCD;
        end
      end
      U_GCD: begin
        if (a_r == '0 || b_r == '0) begin
          state_nxt = (k_r == '0) ? U_DIVN : U_SCALE;
        end
      end
      U_SCALE: begin
        if (k_r == CNT_W'(1)) begin
          state_nxt = U_DIVN;
        end
      end
      U_DIVN: begin
        if (cnt_r == '1) begin
          state_nxt = U_DIVD;
        end
      end
      U_DIVD: begin
        if (cnt_r == '1) begin
          state_nxt = U_DONE;
        end
      end
      U_DONE:  state_nxt = U_IDLE;
      default: state_nxt = U_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    k_nxt   = k_r;
    ma_nxt  = ma_r;
    md_nxt  = md_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    qn_nxt  = qn_r;
    qd_nxt  = qd_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          a_nxt  = req.ma;
          b_nxt  = req.md;
          ma_nxt = req.ma;
          md_nxt = req.md;
          k_nxt  = '0;
        end
      end
      U_GCD: begin
        if (a_r == '0 || b_r == '0) begin
          // The other operand is the odd part of the GCD; load the first division.
          a_nxt   = a_r | b_r;
          rem_nxt = '0;
          quo_nxt = ma_r;
          cnt_nxt = '0;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + CNT_W'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (borrow) begin
          // Both odd with a below b: swap so the next step subtracts.
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = {1'b0, diff[DW-1:1]};
        end
      end
      U_SCALE: begin
        // Restore the common power of two one bit per cycle.
        a_nxt = a_r << 1;
        k_nxt = k_r - CNT_W'(1);
      end
      U_DIVN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == '1) begin
          qn_nxt  = quo_step;
          quo_nxt = md_r;
          rem_nxt = '0;
        end else begin
          quo_nxt = quo_step;
          rem_nxt = rem_step;
        end
      end
      U_DIVD: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        if (cnt_r == '1) begin
          qd_nxt = quo_step;
        end
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done = (state_r == U_DONE);
    rsp.qn   = qn_r;
    rsp.qd   = qd_r;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    ma_r  <= ma_nxt;
    md_r  <= md_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
  end

  // A new request only arrives while the unit is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == U_IDLE)
    else $error("reduce request while the unit is busy");

  // The divider always divides by a nonzero GCD.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_phase |-> a_r != '0)
    else $error("division by zero GCD");

  // The shift count is used up before the divisions begin.
  a_scale_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == U_SCALE && state_nxt == U_DIVN) |=> k_r == '0)
    else $error("GCD scale count not exhausted");

endmodule

`default_nettype wire

// ----- rtl/core/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: fraction add, negate, multiply, divide, add integer and reduce.
// Negate, unused codes and reduce of a zero numerator go straight to the done state; add integer
// takes one product, multiply and divide two, add three (a multiply and an accumulate state each).
// Reduce runs the GCD loop, power-of-two restore and two 32-bit divisions on one subtractor.
// One word is in work at a time: a new word is taken only once the last result has left done.
// Reset (rst_n low, synchronous) clears the sequencers and the output valid flag.
`default_nettype none

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WIDTH = RAU_WIDTH
)(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           in_func,
  input  wire logic signed [DW-1:0] in_num_a,
  input  wire logic signed [DW-1:0] in_den_a,
  input  wire logic signed [DW-1:0] in_num_b,
  input  wire logic signed [DW-1:0] in_den_b,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [DW-1:0]      out_result_num,
  output logic signed [DW-1:0]      out_result_den,
  output logic [1:0]                out_status
);

  rau_state_t              state_r, state_nxt;
  logic [2:0]              func_r, func_nxt;
  logic signed [DW-1:0]    na_r, na_nxt;
  logic signed [DW-1:0]    da_r, da_nxt;
  logic signed [DW-1:0]    nb_r, nb_nxt;
  logic signed [DW-1:0]    db_r, db_nxt;
  logic signed [ACC_W-1:0] acc_n_r, acc_n_nxt;
  logic signed [ACC_W-1:0] acc_d_r, acc_d_nxt;
  logic signed [2*DW-1:0]  prod_r, prod_nxt;
  logic [1:0]              step_r, step_nxt;
  logic signed [DW-1:0]    res_num_r, res_num_nxt;
  logic signed [DW-1:0]    res_den_r, res_den_nxt;
  logic [1:0]              res_stat_r, res_stat_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_fire;
  logic                    out_load;
  rau_uop_t                uop;
  logic signed [DW-1:0]    mul_x, mul_y;
  logic signed [WIDTH-1:0] wr_n, wr_d;
  logic signed [ACC_W-1:0] ext_n, ext_d;
  logic                    ovf;
  rau_red_req_t            red_req;
  rau_red_rsp_t            red_rsp;

  // Reduce unit.
  rau_gcd_div u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (red_req),
    .rsp   (red_rsp)
  );

  // Operand selection for the shared multiplier.
  function automatic logic signed [DW-1:0] opd_val(rau_opd_t s, logic signed [DW-1:0] na,
                                                   logic signed [DW-1:0] da,
                                                   logic signed [DW-1:0] nb,
                                                   logic signed [DW-1:0] db);
    logic signed [DW-1:0] v;
    case (s)
      OPD_NA:  v = na;
      OPD_DA:  v = da;
      OPD_NB:  v = nb;
      default: v = db;
    endcase
    return v;
  endfunction

  assign uop   = uop_of(func_r, step_r);
  assign mul_x = opd_val(uop.x, na_r, da_r, nb_r, db_r);
  assign mul_y = opd_val(uop.y, na_r, da_r, nb_r, db_r);

  // Wrap the exact results to WIDTH bits and flag values that do not fit.
  always_comb begin
    wr_n  = acc_n_r[WIDTH-1:0];
    wr_d  = acc_d_r[WIDTH-1:0];
    ext_n = ACC_W'(wr_n);
    ext_d = ACC_W'(wr_d);
    ovf   = (ext_n != acc_n_r) || (ext_d != acc_d_r);
  end

  // Handshake and reduce request.
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    in_fire       = in_valid && in_ready;
    out_load      = (state_r == ST_DONE) && (!out_valid_r || out_ready);
    red_req.start = in_fire && (in_func == FN_RED) && (in_num_a != '0);
    red_req.ma    = in_num_a[DW-1] ? DW'(-in_num_a) : in_num_a;
    red_req.md    = in_den_a[DW-1] ? DW'(-in_den_a) : in_den_a;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_func)
            FN_ADD, FN_MUL, FN_DIV, FN_ADDI: state_nxt = ST_MUL;
            FN_RED:  state_nxt = (in_num_a != '0) ? ST_RED : ST_DONE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = (step_r == last_step(func_r)) ? ST_DONE : ST_MUL;
      end
      ST_RED: begin
        if (red_rsp.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    func_nxt     = func_r;
    na_nxt       = na_r;
    da_nxt       = da_r;
    nb_nxt       = nb_r;
    db_nxt       = db_r;
    acc_n_nxt    = acc_n_r;
    acc_d_nxt    = acc_d_r;
    prod_nxt     = prod_r;
    step_nxt     = step_r;
    res_num_nxt  = res_num_r;
    res_den_nxt  = res_den_r;
    res_stat_nxt = res_stat_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt = in_func;
          na_nxt   = in_num_a;
          da_nxt   = in_den_a;
          nb_nxt   = in_num_b;
          db_nxt   = in_den_b;
          step_nxt = '0;
          // Starting values: products accumulate on top of these.
          case (in_func)
            FN_ADD, FN_MUL, FN_DIV: begin
              acc_n_nxt = '0;
              acc_d_nxt = '0;
            end
            FN_NEG: begin
              acc_n_nxt = -(ACC_W'(in_num_a));
              acc_d_nxt = ACC_W'(in_den_a);
            end
            FN_ADDI: begin
              acc_n_nxt = ACC_W'(in_num_a);
              acc_d_nxt = ACC_W'(in_den_a);
            end
            default: begin
              acc_n_nxt = '0;
              acc_d_nxt = ACC_W'(1);
            end
          endcase
        end
      end
      ST_MUL: prod_nxt = mul_x * mul_y;
      ST_ACC: begin
        if (uop.to_den) begin
          acc_d_nxt = acc_d_r + ACC_W'(prod_r);
        end else begin
          acc_n_nxt = acc_n_r + ACC_W'(prod_r);
        end
        step_nxt = step_r + 2'd1;
      end
      ST_RED: begin
        // Reduced magnitudes take back the signs of the operands.
        if (red_rsp.done) begin
          acc_n_nxt = na_r[DW-1] ? -(ACC_W'(red_rsp.qn)) : ACC_W'(red_rsp.qn);
          acc_d_nxt = da_r[DW-1] ? -(ACC_W'(red_rsp.qd)) : ACC_W'(red_rsp.qd);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          res_num_nxt = ext_n[DW-1:0];
          res_den_nxt = ext_d[DW-1:0];
          if (ovf) begin
            res_stat_nxt = STAT_OVERFLOW;
          end else if (ext_d[DW-1:0] == '0) begin
            res_stat_nxt = STAT_ZERO_DEN;
          end else begin
            res_stat_nxt = STAT_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_num = res_num_r;
  assign out_result_den = res_den_r;
  assign out_status     = res_stat_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    na_r       <= na_nxt;
    da_r       <= da_nxt;
    nb_r       <= nb_nxt;
    db_r       <= db_nxt;
    acc_n_r    <= acc_n_nxt;
    acc_d_r    <= acc_d_nxt;
    prod_r     <= prod_nxt;
    step_r     <= step_nxt;
    res_num_r  <= res_num_nxt;
    res_den_r  <= res_den_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // The reduce unit only finishes while the sequencer waits for it.
  a_red_done: assert property (@(posedge clk) disable iff (!rst_n)
    red_rsp.done |-> state_r == ST_RED)
    else $error("reduce result outside the reduce wait");

  // The block does not take another word in the cycle after it takes one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input word taken twice in a row");

  // The product schedule never runs past its last step.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ACC |-> step_r <= last_step(func_r))
    else $error("product step out of range");

  // A new result only appears out of the done state.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result valid without a finished word");

endmodule

`default_nettype wire

// ----- tb/rational_arithmetic_unit_test.sv -----
// Self-checking testbench for rational_arithmetic_unit: fraction add, negate, multiply,
// divide, add integer and reduce, checked against an exact-arithmetic predictor.
// Depends on rau_pkg and rational_arithmetic_unit.
`timescale 1ns / 100ps

module rational_arithmetic_unit_test;
  import rau_pkg::*;

  localparam int unsigned RES_W = RAU_WIDTH;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 250;
  localparam int HOLD_CYCLES    = 300;

  localparam logic [2:0] FN_UNUSED6 = 3'd6;
  localparam logic [2:0] FN_UNUSED7 = 3'd7;

  localparam logic signed [DW-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [DW-1:0] S_MAX = 32'sh7fff_ffff;

  // Exact intermediates: a sum of two full products needs 65 bits, one more for margin.
  typedef logic signed [65:0] wide_t;

  typedef struct packed {
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    logic [1:0]    status;
  } frac_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_func = '0;
  logic signed [DW-1:0] in_num_a = '0;
  logic signed [DW-1:0] in_den_a = '0;
  logic signed [DW-1:0] in_num_b = '0;
  logic signed [DW-1:0] in_den_b = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] out_result_num;
  logic signed [DW-1:0] out_result_den;
  logic [1:0]           out_status;

  frac_word_t pending_fracs[$];
  int err_count = 0;
  int idle_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_req = 0;
  int hold_served = 0;

  always #4 clk = ~clk;

  rational_arithmetic_unit #(
    .WIDTH(RES_W)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_num_a       (in_num_a),
    .in_den_a       (in_den_a),
    .in_num_b       (in_num_b),
    .in_den_b       (in_den_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_status     (out_status)
  );

  // Wrap an exact value to the result width, then keep the low field bits.
  function automatic logic [DW-1:0] wrap_to_width(wide_t v);
    wide_t w;
    w = v;
    if (RES_W < 66) w = (v <<< (66 - RES_W)) >>> (66 - RES_W);
    return w[DW-1:0];
  endfunction

  // True when the exact value fits in the result width as a signed number.
  function automatic bit fits_width(wide_t v);
    wide_t lim;
    lim = wide_t'(1) <<< ((RES_W >= 64) ? 63 : (RES_W - 1));
    return (v >= -lim) && (v < lim);
  endfunction

  function automatic logic [32:0] gcd_of(logic [32:0] a, logic [32:0] b);
    logic [32:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Expected fraction and status for one input word, computed exactly.
  function automatic frac_word_t eval_fraction(logic [2:0] f, logic signed [DW-1:0] na,
                                               logic signed [DW-1:0] da,
                                               logic signed [DW-1:0] nb,
                                               logic signed [DW-1:0] db);
    wide_t a_n, a_d, b_n, b_d, n, d, mag;
    logic [32:0] mn, md, g;
    frac_word_t r;
    a_n = wide_t'(na);
    a_d = wide_t'(da);
    b_n = wide_t'(nb);
    b_d = wide_t'(db);
    n = 0;
    d = 1;
    case (f)
      FN_ADD: begin
        n = a_n * b_d + a_d * b_n;
        d = a_d * b_d;
      end
      FN_NEG: begin
        n = -a_n;
        d = a_d;
      end
      FN_MUL: begin
        n = a_n * b_n;
        d = a_d * b_d;
      end
      FN_DIV: begin
        n = a_n * b_d;
        d = a_d * b_n;
      end
      FN_ADDI: begin
        n = a_n + b_n * a_d;
        d = a_d;
      end
      FN_RED: begin
        // A zero numerator reduces to 0/1; otherwise divide by the GCD of the magnitudes.
        if (a_n != 0) begin
          mag = (a_n < 0) ? -a_n : a_n;
          mn = mag[32:0];
          mag = (a_d < 0) ? -a_d : a_d;
          md = mag[32:0];
          g = gcd_of(mn, md);
          n = a_n / wide_t'(g);
          d = a_d / wide_t'(g);
        end
      end
      default: begin
        n = 0;
        d = 1;
      end
    endcase
    r.num = wrap_to_width(n);
    r.den = wrap_to_width(d);
    if (!fits_width(n) || !fits_width(d)) r.status = STAT_OVERFLOW;
    else if (r.den == '0) r.status = STAT_ZERO_DEN;
    else r.status = STAT_OK;
    return r;
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result.
  task automatic send_word(input logic [2:0] f, input logic signed [DW-1:0] na,
                           input logic signed [DW-1:0] da, input logic signed [DW-1:0] nb,
                           input logic signed [DW-1:0] db);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_num_a <= na;
    in_den_a <= da;
    in_num_b <= nb;
    in_den_b <= db;
    do @(posedge clk); while (!in_ready);
    pending_fracs.push_back(eval_fraction(f, na, da, nb, db));
  endtask

  // Operands biased toward zero, unity, the extremes and small values.
  function automatic logic signed [DW-1:0] rand_operand();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return S_MIN;
      4: return S_MAX;
      5, 6: return DW'(int'($urandom_range(200)) - 100);
      7: return DW'(int'($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_word();
    logic [2:0] f;
    logic signed [DW-1:0] na, da, nb, db;
    int k;
    if ($urandom_range(99) < 4) f = $urandom_range(1) ? FN_UNUSED7 : FN_UNUSED6;
    else f = 3'($urandom_range(5));
    na = rand_operand();
    da = rand_operand();
    nb = rand_operand();
    db = rand_operand();
    // Half of the reduce words get a shared factor so that the GCD is nontrivial.
    if (f == FN_RED && $urandom_range(1)) begin
      k = $urandom_range(4096, 1);
      na = DW'(k * (int'($urandom_range(65535)) - 32768));
      da = DW'(k * (int'($urandom_range(65535)) - 32768));
    end
    send_word(f, na, da, nb, db);
  endtask

  // Extremes of each operation and the reduce special cases.
  task automatic test_corner_cases();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    send_word(FN_ADD, 1, 2, 1, 3);
    send_word(FN_ADD, S_MAX, 1, S_MAX, 1);
    send_word(FN_ADD, S_MIN, S_MIN, S_MIN, S_MIN);
    send_word(FN_NEG, 3, 4, 0, 0);
    send_word(FN_NEG, S_MIN, 7, 0, 0);
    send_word(FN_NEG, 5, 0, 0, 0);
    send_word(FN_MUL, 2, 3, 3, 4);
    send_word(FN_MUL, S_MIN, S_MIN, S_MIN, S_MIN);
    send_word(FN_DIV, 1, 2, 0, 5);
    send_word(FN_DIV, -3, 7, 5, -11);
    send_word(FN_ADDI, 1, 3, 2, 0);
    send_word(FN_ADDI, S_MAX, S_MAX, S_MAX, 0);
    send_word(FN_RED, 6, 8, 0, 0);
    send_word(FN_RED, -6, 8, 0, 0);
    send_word(FN_RED, 6, -8, 0, 0);
    send_word(FN_RED, 0, 5, 0, 0);
    send_word(FN_RED, 0, 0, 0, 0);
    send_word(FN_RED, 5, 0, 0, 0);
    send_word(FN_RED, -7, 0, 0, 0);
    send_word(FN_RED, S_MIN, S_MIN, 0, 0);
    send_word(FN_RED, S_MIN, 2, 0, 0);
    send_word(FN_RED, S_MAX, S_MAX, 0, 0);
    send_word(FN_RED, 1, S_MIN, 0, 0);
    send_word(FN_UNUSED6, -1, -1, -1, -1);
    send_word(FN_UNUSED7, S_MIN, S_MAX, S_MIN, S_MAX);
  endtask

  task automatic test_random_traffic(input int count, input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct <= sink_pct;
    repeat (count) send_random_word();
  endtask

  // The receiver holds off long enough for the unit to fill and stall its input.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_req <= hold_req + 1;
    repeat (16) send_random_word();
  endtask

  // Receiver: random stalls, or a counted hold when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_served != hold_req) begin
        hold_served = hold_served + 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    frac_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fracs.size() == 0) begin
        $error("unexpected result word num=%0d den=%0d status=%0d",
               out_result_num, out_result_den, out_status);
        err_count++;
      end else begin
        want = pending_fracs.pop_front();
        if (out_result_num !== want.num) begin
          $error("result_num: expected %0d, got %0d", $signed(want.num), out_result_num);
          err_count++;
        end
        if (out_result_den !== want.den) begin
          $error("result_den: expected %0d, got %0d", $signed(want.den), out_result_den);
          err_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      idle_count = idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("FAIL rational_arithmetic_unit");
        $finish;
      end
    end else begin
      idle_count = 0;
    end
  end

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_cases();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 46, 0);
    test_random_traffic(150, 0, 46);
    test_random_traffic(150, 7, 7);
    test_output_backpressure();
    in_valid <= 1'b0;
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS rational_arithmetic_unit");
    end else begin
      $display("FAIL rational_arithmetic_unit");
    end
    $finish;
  end

endmodule
